// ----- hw/rtl/slrc_pkg.sv -----
package slrc_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_LRC  = 2'd3
  } phase_t;

  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_GOOD = 3'd1;
  localparam logic [2:0] ST_BAD  = 3'd2;
  localparam logic [2:0] ST_OVF  = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;

  localparam logic [1:0] REG_BUFFER_LIMIT = 2'd0;
  localparam logic [1:0] REG_ACK_REPEAT   = 2'd1;
  localparam logic [1:0] REG_ACK_BY_APP   = 2'd2;

  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] NAK_BYTE = 8'h15;

  localparam logic [3:0] MAX_REPLY_REPEAT = 4'd8;

  // result of one item, minus the byte that comes back from the store
  typedef struct packed {
    logic [2:0] frame_status;
    logic [7:0] frame_length;
    logic [7:0] reply_code;
    logic [3:0] reply_count;
    logic       rd_ok;
  } step_res_t;

  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [7:0] addr;
    logic [7:0] wdata;
  } store_req_t;

endpackage

// ----- hw/rtl/slrc_store.sv -----
module slrc_store import slrc_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic       clk,
  input  store_req_t req,
  output logic [7:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/slrc_ctrl.sv -----
module slrc_ctrl import slrc_pkg::*; #(
  parameter int STORE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [1:0] opcode,
  input  logic [7:0] rx_byte,
  input  logic [7:0] read_index,
  input  logic [7:0] buffer_limit,
  input  logic [3:0] ack_repeat,
  input  logic       ack_by_app,
  output step_res_t  res,
  output store_req_t store_req
);

  localparam logic [8:0] DEPTH9 = 9'(STORE_DEPTH);

  phase_t     phase_r, phase_nxt;
  logic [7:0] stored_r, stored_nxt;
  logic [7:0] expected_r, expected_nxt;
  logic [7:0] lrc_r, lrc_nxt;
  logic [7:0] good_r, good_nxt;

  logic       overflow;
  logic [7:0] stored_inc;

  assign overflow   = stored_r > buffer_limit;
  assign stored_inc = stored_r + 8'd1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      case (opcode)
        OP_RX_BYTE: begin
          if (overflow) begin
            phase_nxt = PH_IDLE;
          end else begin
            case (phase_r)
              PH_IDLE: if (rx_byte == SOH_BYTE) phase_nxt = PH_LEN;
              PH_LEN:  phase_nxt = (rx_byte == 8'd0) ? PH_IDLE : PH_DATA;
              PH_DATA: if (stored_inc == expected_r) phase_nxt = PH_LRC;
              PH_LRC:  phase_nxt = PH_IDLE;
              default: phase_nxt = PH_IDLE;
            endcase
          end
        end
        OP_TIMEOUT: phase_nxt = PH_IDLE;
        default:    phase_nxt = phase_r;
      endcase
    end
  end

  // counters, checksum, store access and result
  always_comb begin
    logic [3:0] ack_cnt;
    ack_cnt      = (ack_repeat > MAX_REPLY_REPEAT) ? MAX_REPLY_REPEAT : ack_repeat;
    stored_nxt   = stored_r;
    expected_nxt = expected_r;
    lrc_nxt      = lrc_r;
    good_nxt     = good_r;
    res          = '0;
    store_req    = '0;
    store_req.addr  = (opcode == OP_READ) ? read_index : stored_r;
    store_req.wdata = rx_byte;
    if (step) begin
      case (opcode)
        OP_RX_BYTE: begin
          if (overflow) begin
            stored_nxt       = '0;
            expected_nxt     = '0;
            lrc_nxt          = '0;
            good_nxt         = '0;
            res.frame_status = ST_OVF;
          end else begin
            case (phase_r)
              PH_IDLE: begin
                if (rx_byte == SOH_BYTE) begin
                  stored_nxt   = '0;
                  expected_nxt = '0;
                  lrc_nxt      = '0;
                  good_nxt     = '0;
                end
              end
              PH_LEN: begin
                if (rx_byte != 8'd0) begin
                  expected_nxt = rx_byte;
                  lrc_nxt      = rx_byte;
                end
              end
              PH_DATA: begin
                lrc_nxt         = lrc_r ^ rx_byte;
                store_req.wr_en = {1'b0, stored_r} < DEPTH9;
                stored_nxt      = stored_inc;
              end
              PH_LRC: begin
                if (rx_byte == lrc_r) begin
                  good_nxt         = stored_r;
                  res.frame_status = ST_GOOD;
                  if (!ack_by_app && ack_cnt != 4'd0) begin
                    res.reply_count = ack_cnt;
                    res.reply_code  = ACK_BYTE;
                  end
                end else begin
                  res.frame_status = ST_BAD;
                  if (ack_repeat != 4'd0) begin
                    res.reply_count = 4'd1;
                    res.reply_code  = NAK_BYTE;
                  end
                end
                stored_nxt   = '0;
                expected_nxt = '0;
                lrc_nxt      = '0;
              end
              default: ;
            endcase
          end
        end
        OP_READ: begin
          res.frame_status = ST_READ;
          store_req.rd_en  = 1'b1;
          res.rd_ok        = (read_index < good_r) && ({1'b0, read_index} < DEPTH9);
        end
        OP_TIMEOUT: begin
          stored_nxt   = '0;
          expected_nxt = '0;
          lrc_nxt      = '0;
          good_nxt     = '0;
        end
        default: ;
      endcase
    end
    res.frame_length = good_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      stored_r   <= '0;
      expected_r <= '0;
      lrc_r      <= '0;
      good_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      stored_r   <= stored_nxt;
      expected_r <= expected_nxt;
      lrc_r      <= lrc_nxt;
      good_r     <= good_nxt;
    end
  end

endmodule

// ----- hw/rtl/soh_len_lrc_frame_receiver.sv -----
// Frame receiver for SOH / LEN / data / LRC framing. Every input transaction
// (received byte, payload read, timeout or unused opcode) gives exactly one
// result transaction. A new item is taken every clock cycle while the result
// side keeps up; a result passes through the memory stage, where the accepting
// edge issues the registered read of the payload memory, and then through the
// output register, which waits while the result side stalls. When the result
// side stalls, up to two items are held before the input is stalled. Payload
// bytes live in a single-port STORE_DEPTH x 8 memory that needs no clearing
// after reset; reads are only meaningful below the last good frame length.
// Configuration writes are accepted at once and should be issued only while
// no result is pending.
module soh_len_lrc_frame_receiver import slrc_pkg::*; #(
  parameter int STORE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte[7:0], read_index[15:8]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // frame_length[7:0], reply_code[15:8],
                                  // reply_count[19:16], read_byte[27:20], zero
  output logic [2:0]  out_tuser,  // frame_status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] buffer_limit_r;
  logic [3:0] ack_repeat_r;
  logic       ack_by_app_r;

  logic       in_fire;
  logic       adv;
  step_res_t  res;
  store_req_t store_req;
  logic [7:0] rdata;

  logic       s1_valid_r, s1_valid_nxt;
  step_res_t  s1_res_r;
  logic       out_valid_r, out_valid_nxt;
  logic [31:0] out_tdata_r;
  logic [2:0] out_tuser_r;
  logic [7:0] read_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_limit_r <= 8'd255;
      ack_repeat_r   <= 4'd1;
      ack_by_app_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BUFFER_LIMIT: buffer_limit_r <= cfg_data;
        REG_ACK_REPEAT:   ack_repeat_r   <= cfg_data[3:0];
        REG_ACK_BY_APP:   ack_by_app_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // output register can take the memory stage this cycle
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  slrc_ctrl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_fire),
    .opcode       (in_tuser),
    .rx_byte      (in_tdata[7:0]),
    .read_index   (in_tdata[15:8]),
    .buffer_limit (buffer_limit_r),
    .ack_repeat   (ack_repeat_r),
    .ack_by_app   (ack_by_app_r),
    .res          (res),
    .store_req    (store_req)
  );

  slrc_store #(
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (rdata)
  );

  // memory stage holds while stalled; no new read is issued then
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
  end

  assign read_byte = s1_res_r.rd_ok ? rdata : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_res_r <= res;
    end
    if (adv && s1_valid_r) begin
      out_tdata_r <= {4'd0, read_byte, s1_res_r.reply_count,
                      s1_res_r.reply_code, s1_res_r.frame_length};
      out_tuser_r <= s1_res_r.frame_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- hw/rtl/slrc_checker.sv -----
module slrc_checker import slrc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // a reply byte only comes with a nonzero repeat count, never above the cap
  a_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[19:16] <= MAX_REPLY_REPEAT) &&
                   ((out_tdata[19:16] == 4'd0) == (out_tdata[15:8] == 8'd0)))
    else $error("reply code and count disagree");

  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_READ |-> out_tdata[27:20] == 8'd0)
    else $error("read byte on a non-read result");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:28] == 4'd0 && out_tuser <= ST_READ)
    else $error("bad padding or status code");

endmodule

bind soh_len_lrc_frame_receiver slrc_checker u_slrc_checker (.*);

// ----- sim/soh_len_lrc_frame_receiver_tb.sv -----
`timescale 1ns / 1ps

module soh_len_lrc_frame_receiver_tb;
  import slrc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] length;
    logic [7:0] code;
    logic [3:0] count;
    logic [7:0] rdata;
  } frame_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // rx_byte[7:0], read_index[15:8]
  logic [1:0]  in_tuser;   // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // frame_length[7:0], reply_code[15:8],
                           // reply_count[19:16], read_byte[27:20], zero
  logic [2:0]  out_tuser;  // frame_status[2:0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  soh_len_lrc_frame_receiver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver model state, reset values
  logic [7:0]    limit_cfg  = 8'd255;
  logic [3:0]    repeat_cfg = 4'd1;
  logic          app_ack_cfg = 1'b0;
  phase_t        rx_state   = PH_IDLE;
  logic [7:0]    payload_copy [256];
  logic [7:0]    rx_count   = 8'd0;
  logic [7:0]    want_count = 8'd0;
  logic [7:0]    lrc_acc    = 8'd0;
  logic [7:0]    good_len   = 8'd0;
  int unsigned   store_fill = 0;   // positions [0, store_fill) have been written

  frame_result_t pending_results [$];
  int unsigned   mismatches = 0;
  int unsigned   items_sent = 0;
  int unsigned   hold_off_cycles = 0;
  bit            sender_pace = 1'b1;
  bit            receiver_pace = 1'b1;

  function automatic void drop_frame();
    rx_state   = PH_IDLE;
    rx_count   = 8'd0;
    want_count = 8'd0;
    lrc_acc    = 8'd0;
  endfunction

  function automatic frame_result_t deframe_step(logic [1:0] op, logic [7:0] rx,
                                                 logic [7:0] idx);
    frame_result_t r;
    r = '0;
    case (op)
      OP_RX_BYTE: begin
        if (rx_count > limit_cfg) begin
          drop_frame();
          good_len = 8'd0;
          r.status = ST_OVF;
        end else begin
          case (rx_state)
            PH_IDLE: begin
              if (rx == SOH_BYTE) begin
                drop_frame();
                good_len = 8'd0;
                rx_state = PH_LEN;
              end
            end
            PH_LEN: begin
              if (rx == 8'd0) begin
                rx_state = PH_IDLE;
              end else begin
                want_count = rx;
                lrc_acc    = rx;
                rx_state   = PH_DATA;
              end
            end
            PH_DATA: begin
              lrc_acc = lrc_acc ^ rx;
              payload_copy[rx_count] = rx;
              if (int'(rx_count) + 1 > store_fill) store_fill = int'(rx_count) + 1;
              rx_count = rx_count + 8'd1;
              if (rx_count == want_count) rx_state = PH_LRC;
            end
            default: begin
              if (rx == lrc_acc) begin
                good_len = rx_count;
                r.status = ST_GOOD;
                if (!app_ack_cfg)
                  r.count = (repeat_cfg > MAX_REPLY_REPEAT) ? MAX_REPLY_REPEAT : repeat_cfg;
                if (r.count != 4'd0) r.code = ACK_BYTE;
              end else begin
                r.status = ST_BAD;
                if (repeat_cfg != 4'd0) begin
                  r.count = 4'd1;
                  r.code  = NAK_BYTE;
                end
              end
              drop_frame();
            end
          endcase
        end
      end
      OP_READ: begin
        r.status = ST_READ;
        if (idx < good_len) r.rdata = payload_copy[idx];
      end
      OP_TIMEOUT: begin
        drop_frame();
        good_len = 8'd0;
      end
      default: ;
    endcase
    r.length = good_len;
    return r;
  endfunction

  // compare result transactions first, then predict the accepted input
  always @(posedge clk) begin : result_check
    frame_result_t want;
    frame_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[7:0], out_tdata[15:8], out_tdata[19:16], out_tdata[27:20]};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction: status %0d len %0d code %h count %0d byte %h",
                     got.status, got.length, got.code, got.count, got.rdata);
        end else begin
          want = pending_results.pop_front();
          if (got !== want || out_tdata[31:28] !== 4'd0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected status %0d len %0d code %h count %0d byte %h",
                       want.status, want.length, want.code, want.count, want.rdata);
              $display("  got status %0d len %0d code %h count %0d byte %h pad %h",
                       got.status, got.length, got.code, got.count, got.rdata,
                       out_tdata[31:28]);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(deframe_step(in_tuser, in_tdata[7:0], in_tdata[15:8]));
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      stall = receiver_pace ? $urandom_range(0, 17) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid && hold_off_cycles == 0);
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // leaves tvalid high after the transaction so back-to-back items need no toggle
  task automatic send_item(logic [1:0] op, logic [7:0] rx, logic [7:0] idx);
    int unsigned gap;
    gap = sender_pace ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {idx, rx};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    in_tvalid <= 1'b0;
    // let the last accepted item reach the expected queue first
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BUFFER_LIMIT: limit_cfg   = val;
      REG_ACK_REPEAT:   repeat_cfg  = val[3:0];
      REG_ACK_BY_APP:   app_ack_cfg = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] limit, logic [3:0] rep, bit app);
    write_reg(REG_BUFFER_LIMIT, limit);
    write_reg(REG_ACK_REPEAT, {4'd0, rep});
    write_reg(REG_ACK_BY_APP, {7'd0, app});
  endtask

  // cut_at >= 0 replaces that data byte with a timeout
  task automatic send_frame(int unsigned len, bit bad_lrc, int cut_at);
    logic [7:0] lrc;
    logic [7:0] b;
    send_item(OP_RX_BYTE, SOH_BYTE, 8'($urandom));
    send_item(OP_RX_BYTE, 8'(len), 8'($urandom));
    lrc = 8'(len);
    for (int i = 0; i < int'(len); i++) begin
      if (i == cut_at) begin
        send_item(OP_TIMEOUT, 8'($urandom), 8'($urandom));
        return;
      end
      b = 8'($urandom);
      lrc = lrc ^ b;
      send_item(OP_RX_BYTE, b, 8'($urandom));
    end
    send_item(OP_RX_BYTE, bad_lrc ? (lrc ^ 8'($urandom_range(1, 255))) : lrc, 8'($urandom));
  endtask

  // only positions already written are read
  task automatic send_read();
    logic [7:0] idx;
    if (store_fill == 0) return;
    if ($urandom_range(0, 1) == 0 && good_len != 8'd0)
      idx = 8'($urandom_range(0, good_len - 1));
    else
      idx = 8'($urandom_range(0, store_fill - 1));
    send_item(OP_READ, 8'($urandom), idx);
  endtask

  task automatic test_directed_frames();
    // noise while hunting
    send_item(OP_RX_BYTE, 8'hFF, 8'h00);
    send_item(OP_RX_BYTE, 8'h00, 8'hFF);
    // zero length drops back to hunting
    send_item(OP_RX_BYTE, SOH_BYTE, 8'h00);
    send_item(OP_RX_BYTE, 8'h00, 8'h00);
    // bad lrc, also fills positions 0..2
    send_item(OP_RX_BYTE, SOH_BYTE, 8'h00);
    send_item(OP_RX_BYTE, 8'h03, 8'h00);
    send_item(OP_RX_BYTE, 8'h00, 8'h00);
    send_item(OP_RX_BYTE, 8'hFF, 8'h00);
    send_item(OP_RX_BYTE, 8'h5A, 8'h00);
    send_item(OP_RX_BYTE, 8'h03 ^ 8'h00 ^ 8'hFF ^ 8'h5A ^ 8'h80, 8'h00);
    // good frame
    send_item(OP_RX_BYTE, SOH_BYTE, 8'h00);
    send_item(OP_RX_BYTE, 8'h02, 8'h00);
    send_item(OP_RX_BYTE, 8'hA5, 8'h00);
    send_item(OP_RX_BYTE, 8'h3C, 8'h00);
    send_item(OP_RX_BYTE, 8'h02 ^ 8'hA5 ^ 8'h3C, 8'h00);
    // in range twice, then past the good length
    send_item(OP_READ, 8'h00, 8'd0);
    send_item(OP_READ, 8'hFF, 8'd1);
    send_item(OP_READ, 8'h00, 8'd2);
    // timeout in the middle of the longest frame
    send_item(OP_RX_BYTE, SOH_BYTE, 8'h00);
    send_item(OP_RX_BYTE, 8'hFF, 8'h00);
    send_item(OP_RX_BYTE, 8'h81, 8'h00);
    send_item(OP_TIMEOUT, 8'h00, 8'h00);
    send_item(OP_UNUSED, 8'h00, 8'h00);
  endtask

  task automatic test_overflow_abort();
    set_config(8'd1, 4'd1, 1'b0);
    send_item(OP_RX_BYTE, SOH_BYTE, 8'h00);
    send_item(OP_RX_BYTE, 8'h03, 8'h00);
    send_item(OP_RX_BYTE, 8'h11, 8'h00);
    send_item(OP_RX_BYTE, 8'h22, 8'h00);
    send_item(OP_RX_BYTE, 8'h33, 8'h00);
  endtask

  task automatic test_random_traffic(logic [7:0] limit, logic [3:0] rep, bit app, bit paced,
                                     int unsigned n_items, bit with_long);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    int unsigned n;
    set_config(limit, rep, app);
    sender_pace   = paced;
    receiver_pace = paced;
    start = items_sent;
    if (with_long) begin
      // reaches read positions above 127
      send_frame($urandom_range(129, 160), 1'b0, -1);
      repeat (6) send_read();
    end
    while (items_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if (pick < 55) begin
        send_frame(len, 1'b0, -1);
      end else if (pick < 65) begin
        send_frame(len, 1'b1, -1);
      end else if (pick < 70) begin
        send_frame(len, 1'b0, $urandom_range(0, len - 1));
      end else if (pick < 82) begin
        n = $urandom_range(1, 4);
        repeat (n) send_read();
      end else if (pick < 90) begin
        send_item(OP_RX_BYTE, 8'($urandom), 8'($urandom));
      end else if (pick < 94) begin
        send_item(OP_TIMEOUT, 8'($urandom), 8'($urandom));
      end else if (pick < 97) begin
        send_item(OP_UNUSED, 8'($urandom), 8'($urandom));
      end else begin
        send_item(OP_RX_BYTE, SOH_BYTE, 8'($urandom));
        send_item(OP_RX_BYTE, 8'h00, 8'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    set_config(8'd255, 4'd8, 1'b0);
    sender_pace   = 1'b0;
    receiver_pace = 1'b1;
    hold_off_cycles = 200;
    repeat (5) send_frame(5, 1'b0, -1);
    repeat (4) send_read();
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_overflow_abort();
    test_random_traffic(8'd255, 4'd1, 1'b0, 1'b1, 170, 1'b1);
    test_random_traffic(8'd1, 4'd0, 1'b0, 1'b1, 55, 1'b0);
    test_random_traffic(8'd255, 4'd15, 1'b1, 1'b0, 55, 1'b0);
    test_random_traffic(8'd3, 4'd8, 1'b0, 1'b1, 55, 1'b0);
    test_backpressure();
    test_random_traffic(8'd128, 4'd9, 1'b1, 1'b1, 55, 1'b0);
    test_random_traffic(8'($urandom_range(1, 255)), 4'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)), 1'b1, 55, 1'b0);
    test_random_traffic(8'd255, 4'd15, 1'b0, 1'b1, 55, 1'b0);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/slrc_pkg.sv
hw/rtl/slrc_store.sv
hw/rtl/slrc_ctrl.sv
hw/rtl/soh_len_lrc_frame_receiver.sv
hw/rtl/slrc_checker.sv
sim/soh_len_lrc_frame_receiver_tb.sv
